// ===== hw/rtl/rhps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhps_pkg
// Shared types, constants and modular helpers for the rolling hash splitter.
// ----------------------------------------------------------------------------
package rhps_pkg;

  localparam int unsigned DefaultWindow = 10;
  localparam logic [30:0] KR_PRIME = 31'd1999999973;
  localparam logic [63:0] KrPrimeWide = 64'd1999999973;
  localparam logic [4:0] ByteLast = 5'd7;
  localparam logic [4:0] DivLast = 5'd30;

  typedef enum logic {
    CFG_PHRASE_MODULUS = 1'b0,
    CFG_SENTINEL_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WEIGHT,
    ST_SHIFT,
    ST_DIVIDE,
    ST_OUTPUT
  } back_state_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic [7:0]  oldest;
    logic        rejected;
    logic [31:0] char_index;
  } cmd_t;

  // 256^(window-1) mod prime, worked out at elaboration
  function automatic logic [30:0] kr_weight(input int unsigned window);
    logic [63:0] v;
    int unsigned i;
    v = 64'd1;
    for (i = 1; i < window; i++) begin
      v = (v * 64'd256) % KrPrimeWide;
    end
    return v[30:0];
  endfunction

  // one conditional subtract, input below twice the prime
  function automatic logic [30:0] mod_fix(input logic [31:0] x);
    logic [31:0] d;
    d = x - {1'b0, KR_PRIME};
    return (x >= {1'b0, KR_PRIME}) ? d[30:0] : x[30:0];
  endfunction

endpackage

// ===== hw/rtl/rhps_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhps_cmd_queue
// Two-entry queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module rhps_cmd_queue
  import rhps_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_data
);

  cmd_t mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

endmodule

// ===== hw/rtl/rhps_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhps_front
// Accepts bytes, checks the sentinel, keeps the window, count and halt flag.
// ----------------------------------------------------------------------------
module rhps_front
  import rhps_pkg::*;
#(
  parameter int unsigned WINDOW = DefaultWindow
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic [7:0] sentinel_limit,
  output cmd_t       cmd
);

  logic [7:0] ring [WINDOW];
  logic [31:0] count;
  logic halted;
  logic bad;

  assign bad = halted || (text_byte <= sentinel_limit);

  always_comb begin
    cmd.text_byte = text_byte;
    cmd.oldest = ring[WINDOW-1];
    cmd.rejected = bad;
    cmd.char_index = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      halted <= 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
    end else if (accept) begin
      if (bad) begin
        halted <= 1'b1;
      end else begin
        ring[0] <= text_byte;
        for (int i = 1; i < WINDOW; i++) begin
          ring[i] <= ring[i-1];
        end
        if (count != '1) begin
          count <= count + 32'd1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rhps_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhps_back
// Bit-serial hash update modulo the prime, remainder test, result register.
// ----------------------------------------------------------------------------
module rhps_back
  import rhps_pkg::*;
#(
  parameter int unsigned WINDOW = DefaultWindow
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic [31:0] phrase_modulus,
  input  logic        pop,
  output logic        empty,
  output logic [30:0] window_hash,
  output logic        phrase_end,
  output logic        rejected,
  output logic [31:0] char_index
);

  localparam logic [30:0] Weight = kr_weight(WINDOW);

  back_state_t state, state_next;
  logic [4:0]  cnt;
  logic [30:0] acc;
  logic [30:0] hash_q;
  logic [31:0] rem;
  logic [30:0] dvd;
  logic [7:0]  old_sh;
  logic [7:0]  byte_q;
  logic        rej_q;
  logic [31:0] idx_q;
  logic        phrase_q;
  logic        out_valid;
  logic        out_load;

  logic [30:0] w_dbl, w_next, s_sub, sh_dbl, sh_last;
  logic [31:0] w_sum, s_up;
  logic [32:0] r_try, r_next;

  always_comb begin
    w_dbl = mod_fix({acc, 1'b0});
    w_sum = {1'b0, w_dbl} + {1'b0, Weight};
    w_next = old_sh[7] ? mod_fix(w_sum) : w_dbl;
    s_up = {1'b0, hash_q} + {1'b0, KR_PRIME} - {1'b0, w_next};
    s_sub = (hash_q >= w_next) ? (hash_q - w_next) : s_up[30:0];
    sh_dbl = mod_fix({acc, 1'b0});
    sh_last = mod_fix({1'b0, sh_dbl} + {24'd0, byte_q});
    r_try = {rem, dvd[30]};
    r_next = (r_try >= {1'b0, phrase_modulus}) ? r_try - {1'b0, phrase_modulus} : r_try;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd.rejected ? ST_OUTPUT : ST_WEIGHT;
        end
      end
      ST_WEIGHT: begin
        if (cnt == ByteLast) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (cnt == ByteLast) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (cnt == DivLast) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!out_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = (state == ST_IDLE) && cmd_valid;
    out_load = (state == ST_OUTPUT) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hash_q <= '0;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
        end
        ST_WEIGHT, ST_SHIFT: begin
          cnt <= (cnt == ByteLast) ? 5'd0 : cnt + 5'd1;
        end
        ST_DIVIDE: begin
          cnt <= (cnt == DivLast) ? 5'd0 : cnt + 5'd1;
        end
        ST_OUTPUT: begin
          cnt <= '0;
        end
        default: cnt <= '0;
      endcase
      if (state == ST_SHIFT && cnt == ByteLast) begin
        hash_q <= sh_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        old_sh <= cmd.oldest;
        byte_q <= cmd.text_byte;
        rej_q <= cmd.rejected;
        idx_q <= cmd.char_index;
        phrase_q <= 1'b0;
        acc <= '0;
      end
      ST_WEIGHT: begin
        old_sh <= {old_sh[6:0], 1'b0};
        acc <= (cnt == ByteLast) ? s_sub : w_next;
      end
      ST_SHIFT: begin
        acc <= sh_dbl;
        if (cnt == ByteLast) begin
          dvd <= sh_last;
          rem <= '0;
        end
      end
      ST_DIVIDE: begin
        rem <= r_next[31:0];
        dvd <= {dvd[29:0], 1'b0};
        if (cnt == DivLast) begin
          phrase_q <= (phrase_modulus != '0) && (r_next == '0);
        end
      end
      ST_OUTPUT: begin
        if (out_load) begin
          window_hash <= hash_q;
          phrase_end <= phrase_q;
          rejected <= rej_q;
          char_index <= idx_q;
        end
      end
      default: acc <= '0;
    endcase
  end

  assign empty = !out_valid;

  a_hash_below_prime: assert property (@(posedge clk) disable iff (rst)
    hash_q < KR_PRIME) else $error("hash left the prime field");
  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUTPUT) && out_valid && !pop |=> (state == ST_OUTPUT))
    else $error("result dropped while output stalled");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= DivLast) else $error("step counter out of range");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> (state == ST_WEIGHT) || (state == ST_OUTPUT))
    else $error("command taken outside idle");

endmodule

// ===== hw/rtl/rolling_hash_phrase_splitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_hash_phrase_splitter
// Karp-Rabin rolling hash over a byte window with phrase boundary flags.
// ----------------------------------------------------------------------------
// Input side is a queue: drive text_byte with push while full is low. The
// front part checks the byte against sentinel_limit, updates the window,
// count and halt flag in the transfer cycle and queues a command (two deep).
// The back part works one command at a time: the oldest byte's weight product
// mod the prime, then shifting in the new byte, then restoring remainder
// against phrase_modulus; a rejected byte skips these steps. The back part
// uses a bit-serial modular datapath and takes the next command only once
// the result of the last one is loaded.
// Result side is a queue: the result sits on the ports while empty is low and
// leaves on pop. A stalled result holds; the back part finishes the next byte
// into its own registers and then waits; the front keeps taking bytes until
// the command queue is full.
// Reset clears window, hash, count, halt flag and sets the registers to
// phrase_modulus 100, sentinel_limit 2. Write cfg_* only while idle.
// ----------------------------------------------------------------------------
module rolling_hash_phrase_splitter
  import rhps_pkg::*;
#(
  parameter int unsigned WINDOW = DefaultWindow
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  output logic        empty,
  input  logic        pop,
  output logic [30:0] window_hash,
  output logic        phrase_end,
  output logic        rejected,
  output logic [31:0] char_index,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] phrase_modulus;
  logic [7:0]  sentinel_limit;
  logic        accept;
  cmd_t        cmd_in, cmd_out;
  logic        cmd_valid, cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      phrase_modulus <= 32'd100;
      sentinel_limit <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PHRASE_MODULUS: phrase_modulus <= cfg_data;
        CFG_SENTINEL_LIMIT: sentinel_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  rhps_front #(.WINDOW(WINDOW)) u_front (
    .clk(clk),
    .rst(rst),
    .accept(accept),
    .text_byte(text_byte),
    .sentinel_limit(sentinel_limit),
    .cmd(cmd_in)
  );

  rhps_cmd_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_en(accept),
    .wr_data(cmd_in),
    .full(full),
    .rd_en(cmd_pop),
    .rd_valid(cmd_valid),
    .rd_data(cmd_out)
  );

  rhps_back #(.WINDOW(WINDOW)) u_back (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd(cmd_out),
    .cmd_pop(cmd_pop),
    .phrase_modulus(phrase_modulus),
    .pop(pop),
    .empty(empty),
    .window_hash(window_hash),
    .phrase_end(phrase_end),
    .rejected(rejected),
    .char_index(char_index)
  );

endmodule
